// ----- rtl/core/ddbe_pkg.sv -----
// Shared types and constants for the data directive byte encoder.
// Holds the channel payload structs and the front-to-back command format.
// No dependencies.
package ddbe_pkg;

  localparam int ADDR_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_HALF   = 2'd1;
  localparam logic [1:0] KIND_WORD   = 2'd2;
  localparam logic [1:0] KIND_STRING = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] TEN_LIMIT = 64'd922337203685477580;
  localparam logic [3:0]  POS_LAST_DIGIT = 4'd7;
  localparam logic [3:0]  NEG_LAST_DIGIT = 4'd8;

  typedef struct packed {
    logic [7:0] ch;
    logic [1:0] directive;
    logic       line_start;
  } in_item_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  data_byte;
    logic [15:0] address;
    logic        syntax_error;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        has_data;
    logic [1:0]  nbytes_m1;
    logic [31:0] data;
    logic        has_status;
    logic        err;
  } cmd_t;

endpackage

// ----- rtl/core/data_directive_byte_encoder.sv -----
// Data directive byte encoder: operand text in, data image bytes and
// line status out. Top level; depends on ddbe_pkg and the ddbe_* modules.
//
// Input channel: one character beat per cycle (in_valid / in_stall), with
// the line kind sampled on beats that carry line_start. Output channel:
// result beats (out_valid / out_stall), each a data byte at the data
// counter or an end-of-line status; last marks the final beat caused by
// one character.
// Throughput: one character per cycle while the command queue has room.
// The back end emits one result beat per cycle while out_stall is low;
// a word with status is five beats; the four-entry queue absorbs bursts.
// With the back end idle, the first result beat of a character is
// registered in the queue entry, the command register and the output
// register in turn; further beats of the same character follow one per
// cycle while out_stall is low, later when earlier commands are queued.
// Reset: parser goes idle, queue empties, data counter clears to zero.
// When the receiver stalls, the output beat holds; once the queue fills,
// in_stall rises until the back end drains an entry.
module data_directive_byte_encoder import ddbe_pkg::*; #(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic push, pop, full, empty;
  cmd_t push_cmd, head;

  ddbe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ddbe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  ddbe_back #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/ddbe_front.sv -----
// Front end: line parser and decimal accumulator.
// Turns each character beat into at most one command for the back end.
// Depends on ddbe_pkg.
module ddbe_front import ddbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     full,
  output logic     push,
  output cmd_t     push_cmd
);

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_NSTART  = 8'b0000_0010,
    PH_NSIGN   = 8'b0000_0100,
    PH_NDIGITS = 8'b0000_1000,
    PH_NAFTER  = 8'b0001_0000,
    PH_NCOMMA  = 8'b0010_0000,
    PH_SSTART  = 8'b0100_0000,
    PH_SBODY   = 8'b1000_0000
  } phase_t;

  phase_t      ph_r, ph_nxt, ph_eff;
  logic [1:0]  kind_r, kind_nxt, kind_eff;
  logic        neg_r, neg_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        sat_r, sat_nxt;

  logic        accept;
  logic        is_eol, is_blank, is_digit, is_sign;
  logic [3:0]  digit;
  logic [63:0] thresh, acc_add, lim;
  logic        over;
  logic [31:0] num_value;
  logic [1:0]  size_m1;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  assign is_eol   = (in_data.ch == CH_NUL) || (in_data.ch == CH_LF);
  assign is_blank = in_data.ch inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
  assign is_digit = in_data.ch inside {[CH_ZERO:CH_NINE]};
  assign is_sign  = (in_data.ch == CH_PLUS) || (in_data.ch == CH_MINUS);
  assign digit    = in_data.ch[3:0];

  always_comb begin
    lim = neg_r ? NEG_LIMIT : POS_LIMIT;
    if (neg_r) begin
      thresh = (digit <= NEG_LAST_DIGIT) ? TEN_LIMIT : TEN_LIMIT - 64'd1;
    end else begin
      thresh = (digit <= POS_LAST_DIGIT) ? TEN_LIMIT : TEN_LIMIT - 64'd1;
    end
    over      = acc_r > thresh;
    acc_add   = (acc_r << 3) + (acc_r << 1) + {60'd0, digit};
    num_value = neg_r ? (32'd0 - acc_r[31:0]) : acc_r[31:0];
    case (kind_r)
      KIND_HALF: size_m1 = 2'd1;
      KIND_WORD: size_m1 = 2'd3;
      default:   size_m1 = 2'd0;
    endcase
  end

  always_comb begin
    ph_nxt   = ph_r;
    kind_nxt = kind_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    sat_nxt  = sat_r;
    push     = 1'b0;
    push_cmd = '0;
    kind_eff = kind_r;
    ph_eff   = ph_r;
    if (in_data.line_start) begin
      kind_eff = in_data.directive;
      ph_eff   = (in_data.directive == KIND_STRING) ? PH_SSTART : PH_NSTART;
    end
    kind_nxt = kind_eff;
    ph_nxt   = ph_eff;
    case (ph_eff)
      PH_NSTART, PH_NCOMMA: begin
        if (is_eol) begin
          push = 1'b1;
          push_cmd.has_status = 1'b1;
          push_cmd.err = (ph_eff == PH_NCOMMA);
          ph_nxt = PH_IDLE;
        end else if (is_blank) begin
          ph_nxt = ph_eff;
        end else if (is_digit || is_sign) begin
          sat_nxt = 1'b0;
          if (is_sign) begin
            neg_nxt = (in_data.ch == CH_MINUS);
            acc_nxt = '0;
            ph_nxt  = PH_NSIGN;
          end else begin
            neg_nxt = 1'b0;
            acc_nxt = {60'd0, digit};
            ph_nxt  = PH_NDIGITS;
          end
        end else begin
          push = 1'b1;
          push_cmd.has_status = 1'b1;
          push_cmd.err = 1'b1;
          ph_nxt = PH_IDLE;
        end
      end
      PH_NSIGN, PH_NDIGITS: begin
        if (is_digit) begin
          ph_nxt = PH_NDIGITS;
          if (!sat_r) begin
            if (over) begin
              sat_nxt = 1'b1;
              acc_nxt = lim;
            end else begin
              acc_nxt = acc_add;
            end
          end
        end else if (ph_eff == PH_NSIGN) begin
          push = 1'b1;
          push_cmd.has_status = 1'b1;
          push_cmd.err = 1'b1;
          ph_nxt = PH_IDLE;
        end else begin
          push = 1'b1;
          push_cmd.has_data  = 1'b1;
          push_cmd.nbytes_m1 = size_m1;
          push_cmd.data      = num_value;
          if (is_eol) begin
            push_cmd.has_status = 1'b1;
            ph_nxt = PH_IDLE;
          end else if (is_blank) begin
            ph_nxt = PH_NAFTER;
          end else if (in_data.ch == CH_COMMA) begin
            ph_nxt = PH_NCOMMA;
          end else begin
            push_cmd.has_status = 1'b1;
            push_cmd.err = 1'b1;
            ph_nxt = PH_IDLE;
          end
        end
      end
      PH_NAFTER: begin
        if (is_eol) begin
          push = 1'b1;
          push_cmd.has_status = 1'b1;
          ph_nxt = PH_IDLE;
        end else if (is_blank) begin
          ph_nxt = PH_NAFTER;
        end else if (in_data.ch == CH_COMMA) begin
          ph_nxt = PH_NCOMMA;
        end else begin
          push = 1'b1;
          push_cmd.has_status = 1'b1;
          push_cmd.err = 1'b1;
          ph_nxt = PH_IDLE;
        end
      end
      PH_SSTART: begin
        if (is_eol || !(is_blank || in_data.ch == CH_QUOTE)) begin
          push = 1'b1;
          push_cmd.has_status = 1'b1;
          push_cmd.err = 1'b1;
          ph_nxt = PH_IDLE;
        end else if (in_data.ch == CH_QUOTE) begin
          ph_nxt = PH_SBODY;
        end
      end
      PH_SBODY: begin
        push = 1'b1;
        if (is_eol) begin
          push_cmd.has_status = 1'b1;
          push_cmd.err = 1'b1;
          ph_nxt = PH_IDLE;
        end else if (in_data.ch == CH_QUOTE) begin
          push_cmd.has_data   = 1'b1;
          push_cmd.has_status = 1'b1;
          ph_nxt = PH_IDLE;
        end else begin
          push_cmd.has_data = 1'b1;
          push_cmd.data     = {24'd0, in_data.ch};
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
    if (!accept) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      kind_r <= '0;
      neg_r  <= 1'b0;
      acc_r  <= '0;
      sat_r  <= 1'b0;
    end else if (accept) begin
      ph_r   <= ph_nxt;
      kind_r <= kind_nxt;
      neg_r  <= neg_nxt;
      acc_r  <= acc_nxt;
      sat_r  <= sat_nxt;
    end
  end

endmodule

// ----- rtl/core/ddbe_fifo.sv -----
// Command queue between the parser and the byte emitter.
// Small register queue with a combinational head. Depends on ddbe_pkg.
module ddbe_fifo import ddbe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic empty,
  output cmd_t head
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + PW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + PW'(1) : rd_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/ddbe_back.sv -----
// Back end: expands commands into byte and status result beats.
// Owns the data counter and the output register. Depends on ddbe_pkg.
module ddbe_back import ddbe_pkg::*; #(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      empty,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int EXT_W = (ADDR_WIDTH > 16) ? ADDR_WIDTH : 16;

  logic                  busy_r, busy_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [2:0]            step_r, step_nxt;
  logic [ADDR_WIDTH-1:0] dc_r, dc_nxt;
  logic                  ov_r, ov_nxt;
  out_item_t             od_r, od_nxt;

  logic       fire, done, in_data_phase;
  logic [2:0] n_data, total;
  logic [7:0] sel_byte;
  logic [EXT_W-1:0] dc_ext;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign dc_ext    = EXT_W'(dc_r);

  always_comb begin
    n_data = cmd_r.has_data ? ({1'b0, cmd_r.nbytes_m1} + 3'd1) : 3'd0;
    total  = n_data + {2'd0, cmd_r.has_status};
    in_data_phase = step_r < n_data;
    case (step_r[1:0])
      2'd0:    sel_byte = cmd_r.data[7:0];
      2'd1:    sel_byte = cmd_r.data[15:8];
      2'd2:    sel_byte = cmd_r.data[23:16];
      default: sel_byte = cmd_r.data[31:24];
    endcase
    fire = busy_r && (!ov_r || !out_stall);
    done = fire && (step_r == total - 3'd1);

    ov_nxt   = ov_r && out_stall;
    od_nxt   = od_r;
    dc_nxt   = dc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    cmd_nxt  = cmd_r;
    pop      = 1'b0;

    if (fire) begin
      ov_nxt = 1'b1;
      od_nxt.address = dc_ext[15:0];
      od_nxt.last    = (step_r == total - 3'd1);
      if (in_data_phase) begin
        od_nxt.is_status    = 1'b0;
        od_nxt.data_byte    = sel_byte;
        od_nxt.syntax_error = 1'b0;
        dc_nxt = dc_r + ADDR_WIDTH'(1);
      end else begin
        od_nxt.is_status    = 1'b1;
        od_nxt.data_byte    = '0;
        od_nxt.syntax_error = cmd_r.err;
      end
      step_nxt = step_r + 3'd1;
    end

    if (!busy_r || done) begin
      busy_nxt = !empty;
      pop      = !empty;
      cmd_nxt  = head;
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    od_r  <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      dc_r   <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      dc_r   <= dc_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

// ----- tb/ddbe_checker.sv -----
`timescale 1ns / 100ps
// Checker for the data directive byte encoder: watches both channels, predicts
// the result beats of every accepted character and compares them in order.
// Depends on ddbe_pkg for the payload types and character constants.
module ddbe_checker import ddbe_pkg::*; #(
  parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        beats_in,
  output int        beats_out,
  output int        lines_ok,
  output int        lines_bad
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NUM_START,
    ST_NUM_SIGN,
    ST_NUM_DIGITS,
    ST_NUM_AFTER,
    ST_NUM_COMMA,
    ST_STR_START,
    ST_STR_BODY
  } parse_state_e;

  localparam logic [31:0] ADDR_MASK = (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << ADDR_WIDTH) - 64'd1);

  parse_state_e state = ST_IDLE;
  logic [1:0]   kind = KIND_BYTE;
  logic         neg = 1'b0;
  logic [63:0]  mag = '0;
  logic         sat = 1'b0;
  logic [31:0]  data_cnt = '0;

  out_item_t    expected_q[$];
  out_item_t    beat_res[$];
  out_item_t    want;
  int           fails, n_in, n_out, n_ok, n_bad;

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function void put_byte(logic [7:0] b);
    out_item_t r;
    r = '0;
    r.data_byte = b;
    r.address = data_cnt[15:0];
    beat_res.push_back(r);
    data_cnt = (data_cnt + 32'd1) & ADDR_MASK;
  endfunction

  function void end_line(logic err);
    out_item_t r;
    r = '0;
    r.is_status = 1'b1;
    r.address = data_cnt[15:0];
    r.syntax_error = err;
    beat_res.push_back(r);
    state = ST_IDLE;
  endfunction

  function void begin_number(logic [7:0] c);
    neg = 1'b0;
    mag = '0;
    sat = 1'b0;
    if (c == CH_MINUS || c == CH_PLUS) begin
      neg = (c == CH_MINUS);
      state = ST_NUM_SIGN;
    end else begin
      mag = {56'd0, c - CH_ZERO};
      state = ST_NUM_DIGITS;
    end
  endfunction

  function void add_digit(logic [7:0] c);
    logic [63:0] lim;
    logic [63:0] d;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    d = {56'd0, c - CH_ZERO};
    if (!sat) begin
      if (mag > (lim - d) / 64'd10) begin
        sat = 1'b1;
        mag = lim;
      end else begin
        mag = mag * 64'd10 + d;
      end
    end
  endfunction

  function void emit_number();
    logic [63:0] v;
    int nbytes;
    v = neg ? (64'd0 - mag) : mag;
    nbytes = (kind == KIND_HALF) ? 2 : (kind == KIND_WORD) ? 4 : 1;
    for (int i = 0; i < nbytes; i++) put_byte(v[8*i +: 8]);
  endfunction

  function void after_number(logic [7:0] c, logic eol);
    if (eol) end_line(1'b0);
    else if (c == CH_COMMA) state = ST_NUM_COMMA;
    else if (!is_blank(c)) end_line(1'b1);
  endfunction

  function void predict_beat(in_item_t it);
    logic eol;
    logic [7:0] c;
    c = it.ch;
    eol = (c == CH_NUL || c == CH_LF);
    beat_res.delete();
    if (it.line_start) begin
      kind = it.directive;
      state = (kind == KIND_STRING) ? ST_STR_START : ST_NUM_START;
    end
    case (state)
      ST_NUM_START, ST_NUM_COMMA: begin
        if (eol) end_line(state == ST_NUM_COMMA);
        else if (is_blank(c)) ;
        else if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) begin_number(c);
        else end_line(1'b1);
      end
      ST_NUM_SIGN: begin
        if (is_digit(c)) begin
          add_digit(c);
          state = ST_NUM_DIGITS;
        end else begin
          end_line(1'b1);
        end
      end
      ST_NUM_DIGITS: begin
        if (is_digit(c)) begin
          add_digit(c);
        end else begin
          emit_number();
          state = ST_NUM_AFTER;
          after_number(c, eol);
        end
      end
      ST_NUM_AFTER: after_number(c, eol);
      ST_STR_START: begin
        if (eol) end_line(1'b1);
        else if (is_blank(c)) ;
        else if (c == CH_QUOTE) state = ST_STR_BODY;
        else end_line(1'b1);
      end
      ST_STR_BODY: begin
        if (eol) begin
          end_line(1'b1);
        end else if (c == CH_QUOTE) begin
          put_byte(8'h00);
          end_line(1'b0);
        end else begin
          put_byte(c);
        end
      end
      default: state = ST_IDLE;
    endcase
    if (beat_res.size() > 0) beat_res[beat_res.size() - 1].last = 1'b1;
    foreach (beat_res[i]) expected_q.push_back(beat_res[i]);
  endfunction

  task report_mismatch(input string what, input out_item_t got, input out_item_t ref_beat);
    fails++;
    $display({"%0t: %s: got st=%0b byte=%02h addr=%04h err=%0b last=%0b, ",
              "wanted st=%0b byte=%02h addr=%04h err=%0b last=%0b"},
             $time, what, got.is_status, got.data_byte, got.address, got.syntax_error,
             got.last, ref_beat.is_status, ref_beat.data_byte, ref_beat.address,
             ref_beat.syntax_error, ref_beat.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      state = ST_IDLE;
      kind = KIND_BYTE;
      neg = 1'b0;
      mag = '0;
      sat = 1'b0;
      data_cnt = '0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        n_in++;
        predict_beat(in_data);
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with none expected", out_data, out_data);
        end else begin
          want = expected_q.pop_front();
          if (out_data !== want) report_mismatch("result beat differs", out_data, want);
          if (want.is_status && want.syntax_error) n_bad++;
          else if (want.is_status) n_ok++;
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_q.size();
    beats_in   <= n_in;
    beats_out  <= n_out;
    lines_ok   <= n_ok;
    lines_bad  <= n_bad;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the data directive byte encoder: clock, reset, character
// stimulus in bursts, receiver stalls, watchdog and verdict.
// Depends on ddbe_pkg, data_directive_byte_encoder and ddbe_checker.
module tb_top;
  import ddbe_pkg::*;

  localparam int ITEM_TARGET    = 470;
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count, pending, beats_in, beats_out, lines_ok, lines_bad;

  in_item_t   line_q[$];
  logic [1:0] cur_kind;
  int         burst_left = 0;
  int         chars_sent = 0;
  int         n_lines = 0;
  int         n_drains = 0;
  int         idle_cycles = 0;
  int         stall_mode = 0;
  int         stall_left = 0;

  logic [7:0] blank_set [5] = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};

  data_directive_byte_encoder #(.ADDR_WIDTH(ADDR_WIDTH_DEF)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  ddbe_checker #(.ADDR_WIDTH(ADDR_WIDTH_DEF)) i_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .beats_in  (beats_in),
    .beats_out (beats_out),
    .lines_ok  (lines_ok),
    .lines_bad (lines_bad)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_left <= $urandom_range(10, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(3) == 0);
      2:       out_stall <= ($urandom_range(1) == 0);
      default: out_stall <= ($urandom_range(7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void start_line(logic [1:0] k);
    line_q.delete();
    cur_kind = k;
  endfunction

  function automatic void put_ch(logic [7:0] c);
    in_item_t it;
    it.ch = c;
    it.line_start = (line_q.size() == 0);
    it.directive = it.line_start ? cur_kind : 2'($urandom_range(3));
    line_q.push_back(it);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_ch(s[i]);
  endfunction

  function automatic void put_blanks(int max_n);
    repeat ($urandom_range(max_n)) put_ch(blank_set[$urandom_range(4)]);
  endfunction

  function automatic void put_digits(int n);
    repeat (n) put_ch(CH_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic void put_number();
    int cls;
    case ($urandom_range(9))
      0, 1:    put_ch(CH_MINUS);
      2:       put_ch(CH_PLUS);
      default: ;
    endcase
    cls = $urandom_range(19);
    if (cls < 10) begin
      put_digits($urandom_range(1, 3));
    end else if (cls < 15) begin
      put_digits($urandom_range(4, 10));
    end else if (cls < 18) begin
      // straddle the signed 64-bit limits
      put_str("922337203685477580");
      put_digits(1);
    end else begin
      put_digits($urandom_range(19, 24));
    end
  endfunction

  function automatic void build_numeric();
    int n;
    n = $urandom_range(4);
    put_blanks(2);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        put_ch(CH_COMMA);
        put_blanks(2);
      end
      put_number();
      put_blanks(1);
    end
    put_ch(($urandom_range(3) == 0) ? CH_NUL : CH_LF);
  endfunction

  function automatic void build_string();
    logic [7:0] c;
    put_blanks(2);
    put_ch(CH_QUOTE);
    repeat ($urandom_range(6)) begin
      c = 8'($urandom_range(1, 255));
      if (c == CH_QUOTE || c == CH_LF) c = CH_SPACE;
      put_ch(c);
    end
    put_ch(CH_QUOTE);
    repeat ($urandom_range(2)) put_ch(8'($urandom_range(255)));
    put_ch(CH_LF);
  endfunction

  function automatic void corrupt_line();
    int pos;
    pos = $urandom_range(line_q.size() - 1);
    case ($urandom_range(4))
      0: line_q[pos].ch = 8'($urandom_range(255));
      1: if (pos > 0) line_q.delete(pos);
      2: if (pos > 0) begin
        line_q[pos].line_start = 1'b1;
        line_q[pos].directive = 2'($urandom_range(3));
      end
      3: while (line_q.size() > pos + 2) line_q.delete(pos + 1);
      default: begin
        start_line(2'($urandom_range(3)));
        repeat ($urandom_range(1, 6)) put_ch(8'($urandom_range(255)));
      end
    endcase
  endfunction

  function automatic void build_line();
    start_line(2'($urandom_range(3)));
    if (cur_kind == KIND_STRING) build_string();
    else build_numeric();
    if ($urandom_range(99) >= 75) corrupt_line();
  endfunction

  task automatic send_beat(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_beat(line_q[i]);
    chars_sent += line_q.size();
    n_lines++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    burst_left = 0;
    n_drains++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // characters before any line start: dropped
    start_line(KIND_WORD);
    put_ch(CH_NINE);
    put_ch(CH_LF);
    line_q[0].line_start = 1'b0;
    foreach (line_q[i]) send_beat(line_q[i]);

    start_line(KIND_BYTE);
    put_str(" -1,+7");
    put_ch(CH_LF);
    send_line();
    start_line(KIND_HALF);
    put_ch(CH_LF);
    send_line();
    start_line(KIND_WORD);
    put_str("9,");
    put_ch(CH_NUL);
    send_line();
    start_line(KIND_BYTE);
    put_ch(CH_MINUS);
    put_ch(CH_LF);
    send_line();
    start_line(KIND_HALF);
    put_str("1 2");
    put_ch(CH_LF);
    send_line();
    start_line(KIND_STRING);
    put_str("\"A\"x");
    send_line();
    start_line(KIND_STRING);
    put_ch(CH_QUOTE);
    put_ch(8'hFF);
    put_ch(CH_LF);
    send_line();
    start_line(KIND_STRING);
    put_str("x");
    send_line();
    // restart an open byte line as a word line
    start_line(KIND_BYTE);
    put_str("53");
    line_q[1].line_start = 1'b1;
    line_q[1].directive = KIND_WORD;
    put_ch(CH_LF);
    send_line();
    start_line(KIND_WORD);
    put_ch(CH_COMMA);
    send_line();
    drain_results();

    while (chars_sent < ITEM_TARGET) begin
      build_line();
      send_line();
      if ($urandom_range(39) == 0) drain_results();
    end

    drain_results();
    repeat (12) @(posedge clk);
    $display("covered %0d characters in %0d lines, %0d result beats, %0d full drains",
             beats_in, n_lines, beats_out, n_drains);
    $display("lines closed: %0d accepted, %0d with syntax error, %0d mismatches",
             lines_ok, lines_bad, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- data_directive_byte_encoder.f -----
rtl/core/ddbe_pkg.sv
rtl/core/ddbe_front.sv
rtl/core/ddbe_fifo.sv
rtl/core/ddbe_back.sv
rtl/core/data_directive_byte_encoder.sv
tb/ddbe_checker.sv
tb/tb_top.sv
